@@ sv/tlv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the record file validator.
package tlv_pkg;

	localparam int VERSION_BYTES_DEF = 4;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [24:0] PAY_MAX = 25'h1FFFFFF;
	localparam int FIFO_DEPTH = 4;

	localparam logic [7:0] TYPE_INT = 8'd1;
	localparam logic [7:0] TYPE_STR = 8'd2;
	localparam logic [31:0] INT_LEN = 32'd4;

	typedef enum logic [2:0] {
		REG_MAGIC    = 3'd0,
		REG_VERSION  = 3'd1,
		REG_MAX_REC  = 3'd2,
		REG_MAX_KEY  = 3'd3,
		REG_MAX_STR  = 3'd4,
		REG_MAX_PAY  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ERR_OK        = 4'd0,
		ERR_SHORT     = 4'd1,
		ERR_MAGIC     = 4'd2,
		ERR_VERSION   = 4'd3,
		ERR_COUNT     = 4'd4,
		ERR_PAYLOAD   = 4'd5,
		ERR_HASH      = 4'd6,
		ERR_KEY_LEN   = 4'd7,
		ERR_STR_LEN   = 4'd8,
		ERR_INT_LEN   = 4'd9,
		ERR_TYPE      = 4'd10,
		ERR_TRUNC     = 4'd11,
		ERR_TRAILING  = 4'd12
	} err_t;

	typedef enum logic [2:0] {
		PH_TYPE = 3'd0,
		PH_KLO  = 3'd1,
		PH_KHI  = 3'd2,
		PH_KEY  = 3'd3,
		PH_VLEN = 3'd4,
		PH_VAL  = 3'd5,
		PH_DONE = 3'd6,
		PH_HALT = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_KEY = 2'd0,
		ROLE_INT = 2'd1,
		ROLE_STR = 2'd2
	} role_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [31:0] expected_version;
		logic [20:0] rec_limit;
		logic [15:0] max_key_len;
		logic [23:0] max_string_len;
		logic [23:0] pay_limit;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  out_byte;
		logic [1:0]  byte_role;
		logic        record_end;
		logic [19:0] record_index;
		logic        file_valid;
		logic [3:0]  err_code;
		logic [63:0] sequence_number;
		logic [31:0] records_declared;
		logic        last_result;
	} res_t;

	typedef struct packed {
		logic byte_push;
		logic verdict_push;
	} push_t;

endpackage

@@ sv/tlv_walker.sv @@
`timescale 1ns / 1ps
// Header capture, payload hash and record walk for one byte per cycle while fire is high.
module tlv_walker #(
	parameter int VERSION_BYTES = tlv_pkg::VERSION_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     data_byte,
	input  logic           end_of_file,
	input  tlv_pkg::cfg_t  cfg,
	output tlv_pkg::push_t push,
	output tlv_pkg::res_t  res_byte,
	output tlv_pkg::res_t  res_verdict
);

	localparam logic [4:0] HDR_LEN  = 5'(20 + VERSION_BYTES);
	localparam logic [4:0] OFF_VER  = 5'd4;
	localparam logic [4:0] OFF_CNT  = 5'(4 + VERSION_BYTES);
	localparam logic [4:0] OFF_HASH = 5'(8 + VERSION_BYTES);
	localparam logic [4:0] OFF_SEQ  = 5'(12 + VERSION_BYTES);

	logic [4:0]  header_pos_q, header_pos_d;
	logic [31:0] magic_q, magic_d, version_q, version_d, count_q, count_d, hash_seen_q, hash_seen_d;
	logic [63:0] seq_q, seq_d;
	logic [31:0] hash_q, hash_d;
	logic [24:0] payload_q, payload_d;
	tlv_pkg::phase_t phase_q, phase_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  rtype_q, rtype_d;
	logic [20:0] done_q, done_d;
	logic [3:0]  ferr_q, ferr_d;
	logic [2:0]  vpos_q, vpos_d;
	logic [3:0]  pend_q, pend_d;
	logic        vhigh_q, vhigh_d;

	logic [4:0]  rel_ver, rel_cnt, rel_hash, rel_seq;
	logic [31:0] hx, vlen;
	logic [15:0] klen;
	logic [3:0]  verr, code;
	logic        emit;
	logic [1:0]  emit_role;
	logic        emit_end;

	assign rel_ver  = header_pos_q - OFF_VER;
	assign rel_cnt  = header_pos_q - OFF_CNT;
	assign rel_hash = header_pos_q - OFF_HASH;
	assign rel_seq  = header_pos_q - OFF_SEQ;
	assign hx = hash_q ^ {24'd0, data_byte};
	assign klen = {data_byte, rem_q[7:0]};
	assign vlen = rem_q | ({24'd0, data_byte} << {vpos_q[1:0], 3'd0});

	always_comb begin
		header_pos_d = header_pos_q;
		magic_d = magic_q;
		version_d = version_q;
		count_d = count_q;
		hash_seen_d = hash_seen_q;
		seq_d = seq_q;
		hash_d = hash_q;
		payload_d = payload_q;
		phase_d = phase_q;
		rem_d = rem_q;
		rtype_d = rtype_q;
		done_d = done_q;
		ferr_d = ferr_q;
		vpos_d = vpos_q;
		pend_d = pend_q;
		vhigh_d = vhigh_q;
		emit = 1'b0;
		emit_role = tlv_pkg::ROLE_KEY;
		emit_end = 1'b0;
		verr = tlv_pkg::ERR_OK;

		if (header_pos_q < HDR_LEN) begin
			if (header_pos_q < OFF_VER) begin
				magic_d[{header_pos_q[1:0], 3'd0} +: 8] = data_byte;
			end else if (header_pos_q < OFF_CNT) begin
				if (rel_ver < 5'd4) begin
					version_d[{rel_ver[1:0], 3'd0} +: 8] = data_byte;
				end else if (data_byte != 8'd0) begin
					vhigh_d = 1'b1;
				end
			end else if (header_pos_q < OFF_HASH) begin
				count_d[{rel_cnt[1:0], 3'd0} +: 8] = data_byte;
			end else if (header_pos_q < OFF_SEQ) begin
				hash_seen_d[{rel_hash[1:0], 3'd0} +: 8] = data_byte;
			end else begin
				seq_d[{rel_seq[2:0], 3'd0} +: 8] = data_byte;
			end
			header_pos_d = header_pos_q + 5'd1;
			if (header_pos_d == HDR_LEN) begin
				if (magic_d != cfg.magic_word || vhigh_d || version_d != cfg.expected_version
						|| count_d > {11'd0, cfg.rec_limit}) begin
					phase_d = tlv_pkg::PH_HALT;
				end else begin
					phase_d = (count_d == 32'd0) ? tlv_pkg::PH_DONE : tlv_pkg::PH_TYPE;
				end
			end
		end else begin
			hash_d = 32'(hx * tlv_pkg::FNV_PRIME);
			if (payload_q < tlv_pkg::PAY_MAX) begin
				payload_d = payload_q + 25'd1;
			end
			unique case (phase_q)
				tlv_pkg::PH_TYPE: begin
					rtype_d = data_byte;
					phase_d = tlv_pkg::PH_KLO;
				end
				tlv_pkg::PH_KLO: begin
					rem_d = {24'd0, data_byte};
					phase_d = tlv_pkg::PH_KHI;
				end
				tlv_pkg::PH_KHI: begin
					rem_d = {16'd0, klen};
					if (klen == 16'd0 || klen > cfg.max_key_len) begin
						verr = tlv_pkg::ERR_KEY_LEN;
					end else begin
						phase_d = tlv_pkg::PH_KEY;
					end
				end
				tlv_pkg::PH_KEY: begin
					emit = 1'b1;
					rem_d = rem_q - 32'd1;
					if (rem_d == 32'd0) begin
						phase_d = tlv_pkg::PH_VLEN;
						vpos_d = 3'd0;
					end
				end
				tlv_pkg::PH_VLEN: begin
					rem_d = vlen;
					vpos_d = vpos_q + 3'd1;
					if (vpos_d == 3'd4) begin
						if (rtype_q == tlv_pkg::TYPE_STR && vlen > {8'd0, cfg.max_string_len}) begin
							verr = tlv_pkg::ERR_STR_LEN;
						end else begin
							if (rtype_q == tlv_pkg::TYPE_INT) begin
								pend_d = (vlen != tlv_pkg::INT_LEN) ? tlv_pkg::ERR_INT_LEN
									: tlv_pkg::ERR_OK;
							end else if (rtype_q == tlv_pkg::TYPE_STR) begin
								pend_d = tlv_pkg::ERR_OK;
							end else begin
								pend_d = tlv_pkg::ERR_TYPE;
							end
							if (vlen == 32'd0) begin
								if (pend_d != tlv_pkg::ERR_OK) begin
									verr = pend_d;
								end else begin
									done_d = done_q + 21'd1;
									phase_d = ({11'd0, done_d} == count_q) ? tlv_pkg::PH_DONE
										: tlv_pkg::PH_TYPE;
								end
							end else begin
								phase_d = tlv_pkg::PH_VAL;
							end
						end
					end
				end
				tlv_pkg::PH_VAL: begin
					rem_d = rem_q - 32'd1;
					if (pend_q == tlv_pkg::ERR_OK) begin
						emit = 1'b1;
						emit_role = (rtype_q == tlv_pkg::TYPE_INT) ? tlv_pkg::ROLE_INT
							: tlv_pkg::ROLE_STR;
						emit_end = (rem_d == 32'd0);
					end
					if (rem_d == 32'd0) begin
						if (pend_q != tlv_pkg::ERR_OK) begin
							verr = pend_q;
						end else begin
							done_d = done_q + 21'd1;
							phase_d = ({11'd0, done_d} == count_q) ? tlv_pkg::PH_DONE
								: tlv_pkg::PH_TYPE;
						end
					end
				end
				tlv_pkg::PH_DONE: verr = tlv_pkg::ERR_TRAILING;
				tlv_pkg::PH_HALT: ;
			endcase
			if (verr != tlv_pkg::ERR_OK) begin
				if (ferr_q == tlv_pkg::ERR_OK) begin
					ferr_d = verr;
				end
				phase_d = tlv_pkg::PH_HALT;
			end
		end
	end

	always_comb begin
		priority if (header_pos_d < HDR_LEN) begin
			code = tlv_pkg::ERR_SHORT;
		end else if (payload_d > {1'b0, cfg.pay_limit}) begin
			code = tlv_pkg::ERR_PAYLOAD;
		end else if (magic_d != cfg.magic_word) begin
			code = tlv_pkg::ERR_MAGIC;
		end else if (vhigh_d || version_d != cfg.expected_version) begin
			code = tlv_pkg::ERR_VERSION;
		end else if (count_d > {11'd0, cfg.rec_limit}) begin
			code = tlv_pkg::ERR_COUNT;
		end else if (hash_d != hash_seen_d) begin
			code = tlv_pkg::ERR_HASH;
		end else if (ferr_d != tlv_pkg::ERR_OK) begin
			code = ferr_d;
		end else if (phase_d != tlv_pkg::PH_DONE) begin
			code = tlv_pkg::ERR_TRUNC;
		end else begin
			code = tlv_pkg::ERR_OK;
		end
	end

	always_comb begin
		push.byte_push = fire && emit;
		push.verdict_push = fire && end_of_file;

		res_byte = '0;
		res_byte.out_byte = data_byte;
		res_byte.byte_role = emit_role;
		res_byte.record_end = emit_end;
		res_byte.record_index = done_q[19:0];

		res_verdict = '0;
		res_verdict.kind = 1'b1;
		res_verdict.file_valid = (code == tlv_pkg::ERR_OK);
		res_verdict.err_code = code;
		res_verdict.sequence_number = seq_d;
		res_verdict.records_declared = count_d;
		res_verdict.last_result = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q <= '0;
			magic_q <= '0;
			version_q <= '0;
			count_q <= '0;
			hash_seen_q <= '0;
			seq_q <= '0;
			hash_q <= tlv_pkg::FNV_BASIS;
			payload_q <= '0;
			phase_q <= tlv_pkg::PH_TYPE;
			rem_q <= '0;
			rtype_q <= '0;
			done_q <= '0;
			ferr_q <= tlv_pkg::ERR_OK;
			vpos_q <= '0;
			pend_q <= tlv_pkg::ERR_OK;
			vhigh_q <= 1'b0;
		end else if (fire) begin
			if (end_of_file) begin
				header_pos_q <= '0;
				magic_q <= '0;
				version_q <= '0;
				count_q <= '0;
				hash_seen_q <= '0;
				seq_q <= '0;
				hash_q <= tlv_pkg::FNV_BASIS;
				payload_q <= '0;
				phase_q <= tlv_pkg::PH_TYPE;
				rem_q <= '0;
				rtype_q <= '0;
				done_q <= '0;
				ferr_q <= tlv_pkg::ERR_OK;
				vpos_q <= '0;
				pend_q <= tlv_pkg::ERR_OK;
				vhigh_q <= 1'b0;
			end else begin
				header_pos_q <= header_pos_d;
				magic_q <= magic_d;
				version_q <= version_d;
				count_q <= count_d;
				hash_seen_q <= hash_seen_d;
				seq_q <= seq_d;
				hash_q <= hash_d;
				payload_q <= payload_d;
				phase_q <= phase_d;
				rem_q <= rem_d;
				rtype_q <= rtype_d;
				done_q <= done_d;
				ferr_q <= ferr_d;
				vpos_q <= vpos_d;
				pend_q <= pend_d;
				vhigh_q <= vhigh_d;
			end
		end
	end

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_file |=> header_pos_q == 5'd0 && phase_q == tlv_pkg::PH_TYPE)
		else $error("file state not cleared after last byte");
	a_vlen_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tlv_pkg::PH_VLEN |-> vpos_q < 3'd4)
		else $error("value length byte counter out of range");
	a_emit_body: assert property (@(posedge clk) disable iff (!arst_n)
		push.byte_push |-> header_pos_q == HDR_LEN)
		else $error("record byte passed on during header");

endmodule

@@ sv/tlv_result_fifo.sv @@
`timescale 1ns / 1ps
// Small result queue that takes up to two results per cycle and hands out one per cycle while out_ready is high.
module tlv_result_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  tlv_pkg::push_t push,
	input  tlv_pkg::res_t  res_byte,
	input  tlv_pkg::res_t  res_verdict,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output tlv_pkg::res_t  head
);

	localparam int AW = $clog2(tlv_pkg::FIFO_DEPTH);

	tlv_pkg::res_t mem_q [tlv_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_q, rd_q, wr_second;
	logic [AW:0]   count_q;
	logic          pop;
	logic [AW:0]   n_push;

	assign pop = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign head = mem_q[rd_q];
	// Two free slots are kept so that a record byte and a verdict fit together.
	assign room = (count_q <= (AW+1)'(tlv_pkg::FIFO_DEPTH - 2));
	assign n_push = (AW+1)'(push.byte_push) + (AW+1)'(push.verdict_push);
	assign wr_second = push.byte_push ? wr_q + AW'(1) : wr_q;

	always_ff @(posedge clk) begin
		if (push.byte_push) begin
			mem_q[wr_q] <= res_byte;
		end
		if (push.verdict_push) begin
			mem_q[wr_second] <= res_verdict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[AW-1:0];
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			count_q <= count_q + n_push - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(tlv_pkg::FIFO_DEPTH))
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.byte_push || push.verdict_push) |-> room)
		else $error("result pushed without room");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.byte_push || push.verdict_push) && !pop |=> $stable(count_q))
		else $error("queue count moved without a transaction");

endmodule

@@ sv/tlv_record_file_validator_core.sv @@
`timescale 1ns / 1ps
// Top level of the record file validator: configuration registers, walker and result queue.
// A result is registered in the result queue before it is offered.
// Throughput: one byte per cycle; the last byte of a file that also passes on a
// record byte yields two results, which a four-entry queue hands out one per cycle while out_ready is high.
// Input is taken while the queue has two free entries.
// Reset clears all file state and loads the register defaults; no clearing pass.
module tlv_record_file_validator_core #(
	parameter int VERSION_BYTES = tlv_pkg::VERSION_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_role,
	output logic        record_end,
	output logic [19:0] record_index,
	output logic        file_valid,
	output logic [3:0]  err_code,
	output logic [63:0] sequence_number,
	output logic [31:0] records_declared,
	output logic        last_result,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	tlv_pkg::cfg_t  cfg_q;
	tlv_pkg::push_t push;
	tlv_pkg::res_t  res_byte, res_verdict, head;
	logic           fire, room;

	assign in_ready = room;
	assign fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word <= 32'd0;
			cfg_q.expected_version <= 32'd2;
			cfg_q.rec_limit <= 21'd65536;
			cfg_q.max_key_len <= 16'd256;
			cfg_q.max_string_len <= 24'd4096;
			cfg_q.pay_limit <= 24'd1048576;
		end else if (wr_en) begin
			unique case (wr_index)
				tlv_pkg::REG_MAGIC:   cfg_q.magic_word <= wr_data;
				tlv_pkg::REG_VERSION: cfg_q.expected_version <= wr_data;
				tlv_pkg::REG_MAX_REC: cfg_q.rec_limit <= wr_data[20:0];
				tlv_pkg::REG_MAX_KEY: cfg_q.max_key_len <= wr_data[15:0];
				tlv_pkg::REG_MAX_STR: cfg_q.max_string_len <= wr_data[23:0];
				tlv_pkg::REG_MAX_PAY: cfg_q.pay_limit <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	tlv_walker #(
		.VERSION_BYTES(VERSION_BYTES)
	) u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.cfg(cfg_q),
		.push(push),
		.res_byte(res_byte),
		.res_verdict(res_verdict)
	);

	tlv_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.res_byte(res_byte),
		.res_verdict(res_verdict),
		.room(room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(head)
	);

	assign kind = head.kind;
	assign out_byte = head.out_byte;
	assign byte_role = head.byte_role;
	assign record_end = head.record_end;
	assign record_index = head.record_index;
	assign file_valid = head.file_valid;
	assign err_code = head.err_code;
	assign sequence_number = head.sequence_number;
	assign records_declared = head.records_declared;
	assign last_result = head.last_result;

	a_verdict_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> file_valid == (err_code == tlv_pkg::ERR_OK) && last_result)
		else $error("verdict fields disagree");
	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> !last_result && !file_valid)
		else $error("record byte carries verdict fields");
	a_eof_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_file |-> push.verdict_push)
		else $error("last byte of file produced no verdict");

endmodule
